FILE: hdl/egw_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// egw_pkg
// Shared types and constants of the Exp-Golomb NAL byte-stream writer:
// request and result payloads, request codes and the queued command format.
// ----------------------------------------------------------------------------
package egw_pkg;

	// request codes
	localparam logic [2:0] REQ_FIXED     = 3'd0;
	localparam logic [2:0] REQ_UE        = 3'd1;
	localparam logic [2:0] REQ_SE        = 3'd2;
	localparam logic [2:0] REQ_START     = 3'd3;
	localparam logic [2:0] REQ_END_STOP  = 3'd4;
	localparam logic [2:0] REQ_END_ALIGN = 3'd5;

	localparam logic [31:0] START_CODE  = 32'h0000_0001;
	localparam logic [31:0] UE_OVERFLOW = 32'hFFFF_FFFF;
	localparam logic [7:0]  EPB_BYTE    = 8'h03;
	localparam logic [7:0]  EPB_LIMIT   = 8'h03;
	localparam logic [1:0]  ZRUN_MAX    = 2'd2;

	localparam int FIELD_W = 64;
	localparam int WIN_W   = FIELD_W + 8;

	typedef struct packed {
		logic [2:0]  req_type;
		logic [31:0] value;
		logic [5:0]  bit_count;
		logic [7:0]  nal_header;
	} egw_req_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       is_prevention;
		logic       last;
		logic       error;
	} egw_res_t;

	typedef enum logic [1:0] {
		CMD_BITS,
		CMD_START,
		CMD_ERR
	} cmd_kind_t;

	// bits: field left-aligned (MSB first), len: number of valid bits
	typedef struct packed {
		cmd_kind_t          kind;
		logic               align;
		logic [5:0]         len;
		logic [FIELD_W-1:0] bits;
	} egw_cmd_t;

endpackage
`default_nettype wire

FILE: hdl/h264_rbsp_exp_golomb_writer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// h264_rbsp_exp_golomb_writer
// H.264 NAL byte-stream writer with Exp-Golomb coding and emulation
// prevention.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: one transfer per request (fixed bits, ue, se, start NAL,
//   end with stop bit, end aligned). Unknown request codes are accepted and
//   dropped.
//   res channel: one transfer per stream byte, MSB-first payload packing.
//   The final byte caused by a request carries last. A ue overflow yields a
//   single transfer with error and last set and leaves the stream state alone.
// Path: with the block idle, the first byte of a request passes through
//   decode, sizing, queue write, packer load and the output register; decode
//   is loaded on the transfer edge itself.
// Throughput: the packer loads a request, then emits one result byte a cycle
//   while the receiver takes them, and loads no new request before the last
//   byte is out. Dropped codes and empty fixed fields never reach the packer.
//   The decoder takes one request a cycle unless a stall holds its stages.
// Reset clears the pending partial byte, the zero run and all queues.
// When the receiver stalls, the output register holds, the packer waits and
// the command queue fills; req_ready drops once the queue and decoder stages
// are full.
// ----------------------------------------------------------------------------
module h264_rbsp_exp_golomb_writer #(
	parameter int QUEUE_DEPTH = 4
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	output logic                   req_ready,
	input  wire egw_pkg::egw_req_t req_data,
	output logic                   res_valid,
	input  wire logic              res_ready,
	output egw_pkg::egw_res_t      res_data
);

	// decoder to queue
	logic              fq_valid;
	logic              fq_ready;
	egw_pkg::egw_cmd_t fq_cmd;

	// queue to packer
	logic              qb_valid;
	logic              qb_ready;
	egw_pkg::egw_cmd_t qb_cmd;

	// decode requests, map se, size codes and left-align fields
	egw_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_data  (req_data),
		.cmd_valid (fq_valid),
		.cmd_ready (fq_ready),
		.cmd       (fq_cmd)
	);

	// decouple decoding from byte emission
	egw_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fq_valid),
		.push_ready (fq_ready),
		.push_data  (fq_cmd),
		.pop_valid  (qb_valid),
		.pop_ready  (qb_ready),
		.pop_data   (qb_cmd)
	);

	// pack bits into bytes, insert prevention bytes, drive the output register
	egw_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (qb_valid),
		.cmd_ready (qb_ready),
		.cmd       (qb_cmd),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_data  (res_data)
	);

endmodule
`default_nettype wire

FILE: hdl/egw_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// egw_front
// Request decoder: maps se to ue codes, sizes Exp-Golomb codes and
// left-aligns each bit field into a command for the packer queue.
// ----------------------------------------------------------------------------
module egw_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	output logic                   req_ready,
	input  wire egw_pkg::egw_req_t req_data,
	output logic                   cmd_valid,
	input  wire logic              cmd_ready,
	output egw_pkg::egw_cmd_t      cmd
);

	// stage 1: decoded request
	logic                 valid_s1;
	egw_pkg::cmd_kind_t   kind_s1;
	logic                 ue_s1;
	logic                 align_s1;
	logic [31:0]          field_s1;
	logic [5:0]           count_s1;

	// stage 2: sized field
	logic                 valid_s2;
	egw_pkg::cmd_kind_t   kind_s2;
	logic                 align_s2;
	logic [31:0]          field_s2;
	logic [5:0]           len_s2;

	logic                 ready_s1;
	logic                 ready_s2;

	logic                 dec_drop;
	egw_pkg::cmd_kind_t   dec_kind;
	logic                 dec_ue;
	logic                 dec_align;
	logic [31:0]          dec_field;
	logic [5:0]           dec_count;
	logic [31:0]          fixed_mask;
	logic [31:0]          dbl;

	logic [4:0]           msb;
	logic [6:0]           shamt;

	assign ready_s2  = !valid_s2 || cmd_ready;
	assign ready_s1  = !valid_s1 || ready_s2;
	assign req_ready = ready_s1;

	assign fixed_mask = req_data.bit_count[5] ? '1 : ~({32{1'b1}} << req_data.bit_count[4:0]);
	assign dbl        = {req_data.value[30:0], 1'b0};

	always_comb begin
		dec_drop  = 1'b0;
		dec_kind  = egw_pkg::CMD_BITS;
		dec_ue    = 1'b0;
		dec_align = 1'b0;
		dec_field = '0;
		dec_count = '0;
		case (req_data.req_type)
			egw_pkg::REQ_FIXED: begin
				dec_field = req_data.value & fixed_mask;
				dec_count = req_data.bit_count;
				dec_drop  = (req_data.bit_count == 6'd0);
			end
			egw_pkg::REQ_UE: begin
				if (req_data.value == egw_pkg::UE_OVERFLOW) begin
					dec_kind = egw_pkg::CMD_ERR;
				end else begin
					dec_ue    = 1'b1;
					dec_field = req_data.value + 32'd1;
				end
			end
			egw_pkg::REQ_SE: begin
				dec_ue = 1'b1;
				// code = mapped + 1: 1 - 2v for v <= 0, 2v for v > 0
				if (req_data.value == 32'd0 || req_data.value[31])
					dec_field = 32'd1 - dbl;
				else
					dec_field = dbl;
			end
			egw_pkg::REQ_START: begin
				dec_kind  = egw_pkg::CMD_START;
				dec_field = {24'd0, req_data.nal_header};
			end
			egw_pkg::REQ_END_STOP: begin
				dec_align = 1'b1;
				dec_field = 32'd1;
				dec_count = 6'd1;
			end
			egw_pkg::REQ_END_ALIGN: begin
				dec_align = 1'b1;
			end
			default: begin
				dec_drop = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_s1) begin
			valid_s1 <= req_valid && !dec_drop;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && req_valid) begin
			kind_s1  <= dec_kind;
			ue_s1    <= dec_ue;
			align_s1 <= dec_align;
			field_s1 <= dec_field;
			count_s1 <= dec_count;
		end
	end

	// highest set bit of the code gives the prefix length
	always_comb begin
		msb = '0;
		for (int i = 0; i < 32; i++) begin
			if (field_s1[i])
				msb = 5'(i);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && valid_s1) begin
			kind_s2  <= kind_s1;
			align_s2 <= align_s1;
			field_s2 <= field_s1;
			len_s2   <= ue_s1 ? {msb, 1'b1} : count_s1;
		end
	end

	// left-align the field; a zero length shifts everything out
	assign shamt = 7'(egw_pkg::FIELD_W) - {1'b0, len_s2};

	always_comb begin
		cmd.kind  = kind_s2;
		cmd.align = align_s2;
		cmd.len   = len_s2;
		case (kind_s2)
			egw_pkg::CMD_START: cmd.bits = {egw_pkg::START_CODE, field_s2[7:0], 24'd0};
			egw_pkg::CMD_ERR:   cmd.bits = '0;
			default:            cmd.bits = {32'd0, field_s2} << shamt;
		endcase
	end

	assign cmd_valid = valid_s2;

endmodule
`default_nettype wire

FILE: hdl/egw_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// egw_fifo
// Small command queue between the decoder and the byte packer.
// ----------------------------------------------------------------------------
module egw_fifo #(
	parameter int DEPTH = 4
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push_valid,
	output logic                   push_ready,
	input  wire egw_pkg::egw_cmd_t push_data,
	output logic                   pop_valid,
	input  wire logic              pop_ready,
	output egw_pkg::egw_cmd_t      pop_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	egw_pkg::egw_cmd_t mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              do_push;
	logic              do_pop;

	assign push_ready = (cnt_q != CNT_W'(DEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;
	assign pop_data   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			if (do_push && !do_pop)
				cnt_q <= cnt_q + CNT_W'(1);
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - CNT_W'(1);
		end
	end

endmodule
`default_nettype wire

FILE: hdl/egw_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// egw_back
// Byte packer: merges commands with the pending partial byte, emits completed
// bytes one per cycle unless stalled and inserts emulation prevention bytes.
// ----------------------------------------------------------------------------
module egw_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cmd_valid,
	output logic                   cmd_ready,
	input  wire egw_pkg::egw_cmd_t cmd,
	output logic                   res_valid,
	input  wire logic              res_ready,
	output egw_pkg::egw_res_t      res_data
);

	typedef enum logic {
		ST_LOAD,
		ST_EMIT
	} state_t;

	state_t                        state_q;
	logic [7:0]                    acc_q;     // pending bits, left-aligned
	logic [2:0]                    pc_q;
	logic [1:0]                    zrun_q;
	logic [egw_pkg::WIN_W-1:0]     win_q;
	logic [3:0]                    nb_q;
	logic                          raw_q;
	logic                          err_q;
	logic                          res_valid_q;
	egw_pkg::egw_res_t             res_q;

	logic                          out_free;
	logic [6:0]                    tot;
	logic [egw_pkg::WIN_W-1:0]     merged;
	logic [3:0]                    nb_new;
	logic [7:0]                    top;
	logic                          need_epb;

	assign cmd_ready = (state_q == ST_LOAD);
	assign out_free  = !res_valid_q || res_ready;
	assign res_valid = res_valid_q;
	assign res_data  = res_q;

	assign tot    = 7'(pc_q) + 7'(cmd.len);
	assign merged = {acc_q, {egw_pkg::FIELD_W{1'b0}}} | ({cmd.bits, 8'd0} >> pc_q);
	assign nb_new = cmd.align ? 4'((tot + 7'd7) >> 3) : 4'(tot >> 3);

	assign top      = win_q[egw_pkg::WIN_W-1 -: 8];
	assign need_epb = !raw_q && (zrun_q == egw_pkg::ZRUN_MAX) && (top <= egw_pkg::EPB_LIMIT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			acc_q       <= '0;
			pc_q        <= '0;
			zrun_q      <= '0;
			win_q       <= '0;
			nb_q        <= '0;
			raw_q       <= 1'b0;
			err_q       <= 1'b0;
			res_valid_q <= 1'b0;
			res_q       <= '0;
		end else begin
			if (state_q == ST_EMIT && out_free)
				res_valid_q <= 1'b1;
			else if (res_ready)
				res_valid_q <= 1'b0;
			case (state_q)
				ST_LOAD: begin
					if (cmd_valid) begin
						case (cmd.kind)
							egw_pkg::CMD_START: begin
								win_q   <= {cmd.bits, 8'd0};
								nb_q    <= 4'd5;
								raw_q   <= 1'b1;
								err_q   <= 1'b0;
								pc_q    <= '0;
								zrun_q  <= '0;
								state_q <= ST_EMIT;
							end
							egw_pkg::CMD_ERR: begin
								// park the pending byte behind a dummy zero byte
								win_q   <= {8'd0, acc_q, {(egw_pkg::FIELD_W - 8){1'b0}}};
								nb_q    <= 4'd1;
								raw_q   <= 1'b1;
								err_q   <= 1'b1;
								state_q <= ST_EMIT;
							end
							default: begin
								win_q <= merged;
								nb_q  <= nb_new;
								raw_q <= 1'b0;
								err_q <= 1'b0;
								pc_q  <= cmd.align ? 3'd0 : tot[2:0];
								if (nb_new == 4'd0)
									acc_q <= merged[egw_pkg::WIN_W-1 -: 8];
								else
									state_q <= ST_EMIT;
							end
						endcase
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						if (need_epb) begin
							res_q.data_byte     <= egw_pkg::EPB_BYTE;
							res_q.is_prevention <= 1'b1;
							res_q.last          <= 1'b0;
							res_q.error         <= 1'b0;
							zrun_q              <= '0;
						end else begin
							res_q.data_byte     <= top;
							res_q.is_prevention <= 1'b0;
							res_q.last          <= (nb_q == 4'd1);
							res_q.error         <= err_q;
							if (!raw_q) begin
								if (top != 8'd0)
									zrun_q <= '0;
								else if (zrun_q != egw_pkg::ZRUN_MAX)
									zrun_q <= zrun_q + 2'd1;
							end
							win_q <= win_q << 8;
							nb_q  <= nb_q - 4'd1;
							if (nb_q == 4'd1) begin
								acc_q   <= win_q[egw_pkg::WIN_W-9 -: 8];
								state_q <= ST_LOAD;
							end
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

endmodule
`default_nettype wire
